@@ rtl/gcpw_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package gcpw_pkg;

  // Display geometry
  localparam int unsigned SCREEN_WIDTH = 128;
  localparam int unsigned PAGE_ROWS    = 8;
  localparam int unsigned PAGE_COUNT   = 8;

  // A column of at most 16 rows shifted by up to 7 rows spans at most three pages.
  localparam int unsigned MAX_WRITES   = 3;
  localparam int unsigned ROW_SHIFT_W  = $clog2(PAGE_ROWS);

  localparam int unsigned X_W          = 8;
  localparam int unsigned Y_W          = 7;
  localparam int unsigned COL_W        = 5;
  localparam int unsigned BITS_W       = 16;
  localparam int unsigned GW_W         = 6;
  localparam int unsigned GH_W         = 5;
  localparam int unsigned LM_W         = 7;
  localparam int unsigned SP_W         = 6;

  // Last page index reaches (64 + 15) / 8 = 9 at the clamped row, before the screen check.
  localparam int unsigned PAGE_W       = 5;
  localparam int unsigned XPOS_W       = 9;
  localparam int unsigned SUM_W        = 14;
  localparam int unsigned ADDR_W       = 10;
  localparam int unsigned VALUE_W      = 8;
  localparam int unsigned SHIFT_W      = MAX_WRITES * VALUE_W;
  localparam int unsigned WR_CNT_W     = 2;
  localparam int unsigned WR_IDX_W     = 2;

  localparam int unsigned Y_MAX_RAW    = PAGE_COUNT * PAGE_ROWS;
  localparam int unsigned Y_MAX        = (Y_MAX_RAW > 127) ? 127 : Y_MAX_RAW;

  localparam int unsigned IN_TDATA_W   = ((BITS_W + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA_W  = ((ADDR_W + VALUE_W + 7) / 8) * 8;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned CFG_DATA_W   = 8;

  typedef enum logic {
    CMD_DRAW = 1'b0,
    CMD_HOME = 1'b1
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GLYPH_WIDTH  = 3'd0,
    CFG_GLYPH_HEIGHT = 3'd1,
    CFG_LEFT_MARGIN  = 3'd2,
    CFG_LINE_SPACING = 3'd3,
    CFG_CHAR_SPACING = 3'd4
  } cfg_idx_e;

  // Configuration with glyph width and height already clamped to their usable range.
  typedef struct packed {
    logic [GW_W-1:0] width;
    logic [GH_W-1:0] height;
    logic [LM_W-1:0] left_margin;
    logic [SP_W-1:0] line_spacing;
    logic [SP_W-1:0] char_spacing;
  } cfg_t;

  typedef struct packed {
    logic [X_W-1:0]   x;
    logic [Y_W-1:0]   y;
    logic [COL_W-1:0] col;
  } cursor_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  addr;
    logic [VALUE_W-1:0] value;
  } wr_t;

  typedef struct packed {
    logic [WR_CNT_W-1:0]         count;
    wr_t  [MAX_WRITES-1:0]       wr;
  } batch_t;

endpackage

`default_nettype wire

@@ rtl/gcpw_cfg_regs.sv @@
`timescale 1ns / 1ps
`default_nettype none

module gcpw_cfg_regs
  import gcpw_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  wr_en_i,
  input  wire logic [CFG_IDX_W-1:0]  index_i,
  input  wire logic [CFG_DATA_W-1:0] data_i,
  output cfg_t                       cfg_o
);

  logic [GW_W-1:0] width_q;
  logic [GH_W-1:0] height_q;
  logic [LM_W-1:0] margin_q;
  logic [SP_W-1:0] line_sp_q;
  logic [SP_W-1:0] char_sp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= GW_W'(8);
      height_q  <= GH_W'(10);
      margin_q  <= LM_W'(2);
      line_sp_q <= SP_W'(2);
      char_sp_q <= SP_W'(2);
    end else if (wr_en_i) begin
      unique case (cfg_idx_e'(index_i))
        CFG_GLYPH_WIDTH:  width_q   <= data_i[GW_W-1:0];
        CFG_GLYPH_HEIGHT: height_q  <= data_i[GH_W-1:0];
        CFG_LEFT_MARGIN:  margin_q  <= data_i[LM_W-1:0];
        CFG_LINE_SPACING: line_sp_q <= data_i[SP_W-1:0];
        CFG_CHAR_SPACING: char_sp_q <= data_i[SP_W-1:0];
        default: ;
      endcase
    end
  end

  // Zero acts as one; widths above 32 and heights above 16 saturate.
  always_comb begin
    if (width_q == '0) begin
      cfg_o.width = GW_W'(1);
    end else if (width_q > GW_W'(32)) begin
      cfg_o.width = GW_W'(32);
    end else begin
      cfg_o.width = width_q;
    end
    if (height_q == '0) begin
      cfg_o.height = GH_W'(1);
    end else if (height_q > GH_W'(16)) begin
      cfg_o.height = GH_W'(16);
    end else begin
      cfg_o.height = height_q;
    end
    cfg_o.left_margin  = margin_q;
    cfg_o.line_spacing = line_sp_q;
    cfg_o.char_spacing = char_sp_q;
  end

endmodule

`default_nettype wire

@@ rtl/gcpw_cursor.sv @@
`timescale 1ns / 1ps
`default_nettype none

module gcpw_cursor
  import gcpw_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic step_i,
  input  cmd_e      cmd_i,
  input  cfg_t      cfg_i,
  output cursor_t   cur_o
);

  cursor_t    cur_q, cur_d;
  logic       col_done;
  logic [9:0] adv_x;
  logic       wrap;
  logic [7:0] y_sum;
  logic [7:0] y_clamp;

  always_comb begin
    col_done = (GW_W'(cur_q.col) + GW_W'(1)) >= cfg_i.width;
    adv_x    = 10'(cur_q.x) + 10'(cfg_i.width) + 10'(cfg_i.char_spacing);
    // The wrap test looks at whether another full glyph still fits after advancing.
    wrap     = (adv_x + 10'(cfg_i.width)) > 10'(SCREEN_WIDTH);
    y_sum    = 8'(cur_q.y) + 8'(cfg_i.height) + 8'(cfg_i.line_spacing);
    y_clamp  = (y_sum > 8'(Y_MAX)) ? 8'(Y_MAX) : y_sum;

    cur_d = cur_q;
    if (step_i) begin
      unique case (cmd_i)
        CMD_HOME: begin
          cur_d.x   = X_W'(cfg_i.left_margin);
          cur_d.y   = '0;
          cur_d.col = '0;
        end
        CMD_DRAW: begin
          if (col_done) begin
            cur_d.col = '0;
            if (wrap) begin
              cur_d.x = X_W'(cfg_i.left_margin);
              cur_d.y = y_clamp[Y_W-1:0];
            end else begin
              cur_d.x = adv_x[X_W-1:0];
            end
          end else begin
            cur_d.col = cur_q.col + COL_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q <= '0;
    end else begin
      cur_q <= cur_d;
    end
  end

  assign cur_o = cur_q;

endmodule

`default_nettype wire

@@ rtl/gcpw_page_split.sv @@
`timescale 1ns / 1ps
`default_nettype none

module gcpw_page_split
  import gcpw_pkg::*;
(
  input  wire logic              draw_i,
  input  wire logic [BITS_W-1:0] bits_i,
  input  cfg_t                   cfg_i,
  input  cursor_t                cur_i,
  output batch_t                 batch_o
);

  logic [BITS_W-1:0]  mask;
  logic [SHIFT_W-1:0] shifted;
  logic [PAGE_W-1:0]  first_page;
  logic [PAGE_W-1:0]  last_page;
  logic [PAGE_W-1:0]  span;
  logic [7:0]         y_end;
  logic [XPOS_W-1:0]  x_pos;
  logic               on_screen;
  logic [PAGE_W-1:0]  page     [MAX_WRITES];
  logic [SUM_W-1:0]   addr_sum [MAX_WRITES];
  logic [MAX_WRITES-1:0] pv;
  logic [WR_CNT_W-1:0]   count;

  always_comb begin
    mask       = BITS_W'((17'd1 << cfg_i.height) - 17'd1);
    shifted    = SHIFT_W'(bits_i & mask) << cur_i.y[ROW_SHIFT_W-1:0];
    first_page = PAGE_W'(cur_i.y >> ROW_SHIFT_W);
    y_end      = 8'(cur_i.y) + 8'(cfg_i.height) - 8'd1;
    last_page  = PAGE_W'(y_end >> ROW_SHIFT_W);
    span       = last_page - first_page;
    x_pos      = XPOS_W'(cur_i.x) + XPOS_W'(cur_i.col);
    on_screen  = draw_i && (x_pos < XPOS_W'(SCREEN_WIDTH));
    count      = '0;
    for (int j = 0; j < MAX_WRITES; j++) begin
      page[j]     = first_page + PAGE_W'(j);
      // Pages past the bottom of the screen are dropped; valid pages stay contiguous.
      pv[j]       = on_screen && (PAGE_W'(j) <= span) && (page[j] < PAGE_W'(PAGE_COUNT));
      addr_sum[j] = SUM_W'(page[j]) * SUM_W'(SCREEN_WIDTH) + SUM_W'(x_pos);
      batch_o.wr[j].addr  = addr_sum[j][ADDR_W-1:0];
      batch_o.wr[j].value = shifted[j*VALUE_W +: VALUE_W];
      count = count + WR_CNT_W'(pv[j]);
    end
    batch_o.count = count;
  end

endmodule

`default_nettype wire

@@ rtl/gcpw_out_buf.sv @@
`timescale 1ns / 1ps
`default_nettype none

module gcpw_out_buf
  import gcpw_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic load_i,
  input  batch_t    batch_i,
  input  wire logic ready_i,
  output logic      valid_o,
  output wr_t       wr_o,
  output logic      last_o,
  output logic      free_o
);

  wr_t                 entries_q [MAX_WRITES];
  logic [WR_CNT_W-1:0] cnt_q;
  logic [WR_IDX_W-1:0] rd_q;
  logic                take;

  assign valid_o = (cnt_q != '0);
  assign last_o  = (WR_CNT_W'(rd_q) + WR_CNT_W'(1)) == cnt_q;
  assign wr_o    = entries_q[rd_q];
  assign take    = valid_o && ready_i;
  // A new batch may land in the same cycle the final item of the old one leaves.
  assign free_o  = !valid_o || (take && last_o);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rd_q  <= '0;
    end else if (load_i) begin
      cnt_q <= batch_i.count;
      rd_q  <= '0;
    end else if (take) begin
      if (last_o) begin
        cnt_q <= '0;
        rd_q  <= '0;
      end else begin
        rd_q <= rd_q + WR_IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      for (int j = 0; j < MAX_WRITES; j++) begin
        entries_q[j] <= batch_i.wr[j];
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/glyph_column_page_writer.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Glyph column to page buffer writer.
// Slave stream: one item per glyph column; tuser selects draw (0) or cursor home (1),
// tdata carries the column pixels with bit 0 as the top row.
// Master stream: one item per byte write into the page buffer; tlast marks the final
// write caused by a column. A column yields zero to three writes; home yields none.
// Config channel: register index and data, always ready; write only while idle.
// An accepted item is held in the input register and moves into the write buffer once
// the buffer is free; tvalid then rises with the item's first write, if it yields any.
// Throughput: one column per cycle while the receiver stays ready and each column yields at
// most one write; otherwise the single master port sets the pace, up to three writes per column.
// The next input item is taken while results of the previous one are still draining.
// When the receiver stalls, the write buffer holds, the input register fills and
// tready drops; nothing is lost.
// Reset clears the cursor to column 0, row 0, glyph column 0, empties both stages,
// and loads width 8, height 10, left margin 2, line spacing 2, char spacing 2.
module glyph_column_page_writer
  import gcpw_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata_i,  // [15:0] column_bits
  input  wire logic                   s_axis_tuser_i,  // [0] cmd
  output logic                        m_axis_tvalid_o,
  input  wire logic                   m_axis_tready_i,
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata_o,  // [9:0] byte_address, [17:10] byte_value
  output logic                        m_axis_tlast_o,
  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data_i
);

  logic              in_valid_q;
  cmd_e              cmd_q;
  logic [BITS_W-1:0] bits_q;
  logic              load;
  logic              buf_free;
  cfg_t              cfg;
  cursor_t           cursor;
  batch_t            batch;
  wr_t               wr;

  assign cfg_ready_o = 1'b1;

  gcpw_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_en_i (cfg_valid_i),
    .index_i (cfg_index_i),
    .data_i  (cfg_data_i),
    .cfg_o   (cfg)
  );

  assign load            = in_valid_q && buf_free;
  assign s_axis_tready_o = !in_valid_q || load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_valid_q <= 1'b1;
    end else if (load) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      cmd_q  <= cmd_e'(s_axis_tuser_i);
      bits_q <= s_axis_tdata_i[BITS_W-1:0];
    end
  end

  gcpw_cursor u_cursor (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (load),
    .cmd_i  (cmd_q),
    .cfg_i  (cfg),
    .cur_o  (cursor)
  );

  gcpw_page_split u_split (
    .draw_i  (cmd_q == CMD_DRAW),
    .bits_i  (bits_q),
    .cfg_i   (cfg),
    .cur_i   (cursor),
    .batch_o (batch)
  );

  gcpw_out_buf u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (load),
    .batch_i (batch),
    .ready_i (m_axis_tready_i),
    .valid_o (m_axis_tvalid_o),
    .wr_o    (wr),
    .last_o  (m_axis_tlast_o),
    .free_o  (buf_free)
  );

  assign m_axis_tdata_o = OUT_TDATA_W'({wr.value, wr.addr});

  // A batch never overwrites a write that has not been taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> (!m_axis_tvalid_o || (m_axis_tready_i && m_axis_tlast_o)))
    else $error("page write batch loaded over pending writes");

  // Homing the cursor produces no writes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && (cmd_q == CMD_HOME)) |=> !m_axis_tvalid_o)
    else $error("home command produced a write");

  // The cursor row never exceeds the clamp value Y_MAX, the first row past the screen bottom.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cursor.y <= Y_W'(Y_MAX))
    else $error("cursor row beyond clamp");

endmodule

`default_nettype wire

@@ sim/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import gcpw_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PHASES      = 6;
  localparam int unsigned PHASE_ITEMS = 50;
  localparam int unsigned SETTLE      = 10;

  typedef struct packed {
    logic [ADDR_W-1:0]  addr;
    logic [VALUE_W-1:0] value;
    logic               last;
  } page_write_t;

  typedef struct {
    bit                    is_cfg;
    cfg_idx_e              idx;
    logic [CFG_DATA_W-1:0] val;
    cmd_e                  cmd;
    logic [BITS_W-1:0]     bits;
    bit                    typed;
    int unsigned           n;
    logic [ADDR_W-1:0]     a0, a1;
    logic [VALUE_W-1:0]    v0, v1;
  } script_row_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid_i = 1'b0;
  logic                   s_axis_tready_o;
  logic [IN_TDATA_W-1:0]  s_axis_tdata_i = '0;   // [15:0] column_bits
  logic                   s_axis_tuser_i = 1'b0; // [0] cmd
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;        // [9:0] byte_address, [17:10] byte_value
  logic                   m_axis_tlast_o;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i = '0;

  // Shadow copy of the block's registers and cursor.
  logic [GW_W-1:0]  reg_width    = 6'd8;
  logic [GH_W-1:0]  reg_height   = 5'd10;
  logic [LM_W-1:0]  reg_margin   = 7'd2;
  logic [SP_W-1:0]  reg_line_gap = 6'd2;
  logic [SP_W-1:0]  reg_char_gap = 6'd2;
  logic [X_W-1:0]   cur_x   = '0;
  logic [Y_W-1:0]   cur_y   = '0;
  logic [COL_W-1:0] cur_col = '0;

  page_write_t pending_writes[$];
  script_row_t script[$];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned stall_left = 0;
  bit          calm = 1'b0;

  glyph_column_page_writer uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 19);
    if (r < 12) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (mismatches < 50)
      $display("mismatch on %s: got %0d, expected %0d", what, got, want);
    mismatches++;
  endtask

  // Works out the page writes caused by one item and moves the cursor on.
  task automatic model_column(input cmd_e cmd, input logic [BITS_W-1:0] bits,
                              input bit keep);
    int unsigned w, h, x, first_page, last_page, n, nx, ny;
    logic [31:0] shifted;
    page_write_t batch[MAX_WRITES];
    if (cmd == CMD_HOME) begin
      cur_x = X_W'(reg_margin);
      cur_y = '0;
      cur_col = '0;
      return;
    end
    w = (reg_width == 0) ? 1 : (reg_width > 32) ? 32 : reg_width;
    h = (reg_height == 0) ? 1 : (reg_height > 16) ? 16 : reg_height;
    shifted = (32'(bits) & ((32'd1 << h) - 1)) << (cur_y % PAGE_ROWS);
    first_page = cur_y / PAGE_ROWS;
    last_page = (cur_y + h - 1) / PAGE_ROWS;
    x = cur_x + cur_col;
    n = 0;
    if (x < SCREEN_WIDTH) begin
      for (int unsigned p = first_page;
           p <= last_page && n < MAX_WRITES && p < PAGE_COUNT; p++) begin
        batch[n].addr = ADDR_W'(p * SCREEN_WIDTH + x);
        batch[n].value = VALUE_W'(shifted >> (8 * (p - first_page)));
        batch[n].last = 1'b0;
        n++;
      end
    end
    if (n > 0) batch[n-1].last = 1'b1;
    if (keep)
      for (int i = 0; i < n; i++) pending_writes.push_back(batch[i]);

    if (cur_col + 1 >= w) begin
      cur_col = '0;
      nx = cur_x + w + reg_char_gap;
      // The wrap test looks at where the next glyph would end.
      if (nx + w > SCREEN_WIDTH) begin
        ny = cur_y + h + reg_line_gap;
        if (ny > Y_MAX) ny = Y_MAX;
        cur_y = Y_W'(ny);
        nx = reg_margin;
      end
      cur_x = X_W'(nx);
    end else begin
      cur_col = cur_col + 1'b1;
    end
  endtask

  task automatic cfg_write(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_GLYPH_WIDTH:  reg_width = val[GW_W-1:0];
      CFG_GLYPH_HEIGHT: reg_height = val[GH_W-1:0];
      CFG_LEFT_MARGIN:  reg_margin = val[LM_W-1:0];
      CFG_LINE_SPACING: reg_line_gap = val[SP_W-1:0];
      CFG_CHAR_SPACING: reg_char_gap = val[SP_W-1:0];
      default: ;
    endcase
  endtask

  // Register writes always come right before an item, so the item lowers cfg_valid_i.
  task automatic send_item(input cmd_e cmd, input logic [BITS_W-1:0] bits,
                           input bit keep);
    int unsigned gap;
    cfg_valid_i <= 1'b0;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= IN_TDATA_W'(bits);
    s_axis_tuser_i <= cmd;
    do @(posedge clk_i); while (!s_axis_tready_o);
    model_column(cmd, bits, keep);
    gap = pick_gap();
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Items that cause no write may still be in flight once the queue is empty.
  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic add_cfg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] val);
    script_row_t row;
    row = '{idx: CFG_GLYPH_WIDTH, cmd: CMD_DRAW, default: '0};
    row.is_cfg = 1'b1;
    row.idx = idx;
    row.val = val;
    script.push_back(row);
  endtask

  task automatic add_item(input cmd_e cmd, input logic [BITS_W-1:0] bits);
    script_row_t row;
    row = '{idx: CFG_GLYPH_WIDTH, cmd: CMD_DRAW, default: '0};
    row.cmd = cmd;
    row.bits = bits;
    script.push_back(row);
  endtask

  task automatic add_known(input cmd_e cmd, input logic [BITS_W-1:0] bits,
                           input int unsigned n,
                           input logic [ADDR_W-1:0] a0, input logic [VALUE_W-1:0] v0,
                           input logic [ADDR_W-1:0] a1, input logic [VALUE_W-1:0] v1);
    script_row_t row;
    row = '{idx: CFG_GLYPH_WIDTH, cmd: CMD_DRAW, default: '0};
    row.cmd = cmd;
    row.bits = bits;
    row.typed = 1'b1;
    row.n = n;
    row.a0 = a0;
    row.v0 = v0;
    row.a1 = a1;
    row.v1 = v1;
    script.push_back(row);
  endtask

  always @(posedge clk_i) begin : receiver
    int unsigned g;
    if (stall_left != 0) begin
      m_axis_tready_i <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      g = pick_gap();
      m_axis_tready_i <= (g == 0);
      stall_left <= (g == 0) ? 0 : g - 1;
    end
  end

  always @(posedge clk_i) begin : write_checker
    page_write_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_writes.size() == 0) begin
        report_mismatch("unexpected write, address", m_axis_tdata_o[ADDR_W-1:0], 0);
      end else begin
        want = pending_writes.pop_front();
        if (m_axis_tdata_o[ADDR_W-1:0] != want.addr)
          report_mismatch("byte_address", m_axis_tdata_o[ADDR_W-1:0], want.addr);
        if (m_axis_tdata_o[ADDR_W +: VALUE_W] != want.value)
          report_mismatch("byte_value", m_axis_tdata_o[ADDR_W +: VALUE_W], want.value);
        if (m_axis_tlast_o != want.last)
          report_mismatch("last_write", m_axis_tlast_o, want.last);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  initial begin : stimulus
    page_write_t wr;
    bit prev_cfg;
    logic [CFG_DATA_W-1:0] v_width, v_height, v_margin, v_line, v_char;
    int unsigned r;
    cmd_e cmd;
    logic [BITS_W-1:0] bits;

    // Reset settings: the cursor starts at column 0, row 0.
    add_known(CMD_DRAW, 16'hFFFF, 2, 10'd0, 8'hFF, 10'd128, 8'h03);
    add_known(CMD_DRAW, 16'h0000, 2, 10'd1, 8'h00, 10'd129, 8'h00);
    add_known(CMD_HOME, 16'hFFFF, 0, '0, '0, '0, '0);
    add_known(CMD_DRAW, 16'h0001, 2, 10'd2, 8'h01, 10'd130, 8'h00);
    // Pixels above the glyph height are dropped.
    add_known(CMD_DRAW, 16'hFC00, 2, 10'd3, 8'h00, 10'd131, 8'h00);
    // Width 0 acts as 1, height above 16 acts as 16, widest margins and gaps.
    add_cfg(CFG_GLYPH_WIDTH, 8'd0);
    add_cfg(CFG_GLYPH_HEIGHT, 8'h1F);
    add_cfg(CFG_LEFT_MARGIN, 8'h7F);
    add_cfg(CFG_LINE_SPACING, 8'h3F);
    add_cfg(CFG_CHAR_SPACING, 8'h3F);
    add_item(CMD_HOME, 16'h0000);
    add_known(CMD_DRAW, 16'hFFFF, 2, 10'd127, 8'hFF, 10'd255, 8'hFF);
    // The wrap pushed the cursor to the clamped row, below the screen.
    add_known(CMD_DRAW, 16'hA5A5, 0, '0, '0, '0, '0);
    add_cfg(CFG_LEFT_MARGIN, 8'd0);
    add_cfg(CFG_LINE_SPACING, 8'd3);
    add_item(CMD_HOME, 16'h1234);
    add_item(CMD_DRAW, 16'hFFFF);
    add_item(CMD_DRAW, 16'h8001);
    // Row 19 after the wrap: the column straddles three pages.
    add_item(CMD_DRAW, 16'hFFFF);
    add_item(CMD_DRAW, 16'h8000);
    // Width above 32 acts as 32; the second column falls off the right edge.
    add_cfg(CFG_GLYPH_WIDTH, 8'hFF);
    add_cfg(CFG_LEFT_MARGIN, 8'hFF);
    add_item(CMD_HOME, 16'h0000);
    add_item(CMD_DRAW, 16'h5555);
    add_known(CMD_DRAW, 16'hFFFF, 0, '0, '0, '0, '0);
    // Height 0 acts as 1.
    add_cfg(CFG_GLYPH_HEIGHT, 8'd0);
    add_item(CMD_HOME, 16'hFFFF);
    add_known(CMD_DRAW, 16'hFFFE, 1, 10'd127, 8'h00, '0, '0);
    add_known(CMD_DRAW, 16'h0001, 0, '0, '0, '0, '0);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    prev_cfg = 1'b0;
    foreach (script[i]) begin
      if (script[i].is_cfg) begin
        if (!prev_cfg) wait_drained();
        cfg_write(script[i].idx, script[i].val);
      end else begin
        // Typed writes are queued before the item goes out, ahead of any sender gap.
        for (int j = 0; j < script[i].n; j++) begin
          wr.addr = (j == 0) ? script[i].a0 : script[i].a1;
          wr.value = (j == 0) ? script[i].v0 : script[i].v1;
          wr.last = (j == script[i].n - 1);
          pending_writes.push_back(wr);
        end
        send_item(script[i].cmd, script[i].bits, !script[i].typed);
      end
      prev_cfg = script[i].is_cfg;
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      wait_drained();
      calm = (phase == 3);
      case (phase)
        0: begin
          {v_width, v_height, v_margin, v_line, v_char} = '0;
        end
        1: begin
          {v_width, v_height, v_margin, v_line, v_char} = '1;
        end
        default: begin
          v_width = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(1, 8));
          v_height = 8'($urandom);
          v_margin = 8'($urandom);
          v_line = 8'($urandom_range(0, 7));
          v_char = ($urandom_range(0, 1) == 0) ? 8'($urandom) : 8'($urandom_range(0, 4));
        end
      endcase
      cfg_write(CFG_GLYPH_WIDTH, v_width);
      cfg_write(CFG_GLYPH_HEIGHT, v_height);
      cfg_write(CFG_LEFT_MARGIN, v_margin);
      cfg_write(CFG_LINE_SPACING, v_line);
      cfg_write(CFG_CHAR_SPACING, v_char);
      send_item(CMD_HOME, 16'($urandom), 1'b1);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // Once in the run, hold the sender until every write has come out.
        if (phase == 2 && k == PHASE_ITEMS / 2) wait_drained();
        r = $urandom_range(0, 19);
        cmd = (r == 0) ? CMD_HOME : CMD_DRAW;
        bits = (r == 1) ? 16'h0000 : (r == 2) ? 16'hFFFF : 16'($urandom);
        send_item(cmd, bits, 1'b1);
      end
    end

    calm = 1'b0;
    wait_drained();
    if (mismatches == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
